### hdl/cpts_pkg.sv
package cpts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int PRIO_BITS  = 8;
  localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
  localparam int CNT_BITS   = 10;
  localparam int DEPTH_BITS = 8;
  localparam int SUM_BITS   = ((PRIO_BITS > CNT_BITS) ? PRIO_BITS : CNT_BITS) + 1;
  localparam int SCAN_BITS  = $clog2(TASK_SLOTS + 1);

  localparam logic [CNT_BITS-1:0]   SLICE_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  // Request codes carried in the req_type field of an input word.
  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_YIELD    = 3'd1,
    REQ_ADD      = 3'd2,
    REQ_DISABLE  = 3'd3,
    REQ_ENABLE   = 3'd4,
    REQ_SET_RUN  = 3'd5
  } req_e;

  // Operations broadcast from the controller to every cell.
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_TICK    = 3'd1,
    OP_YIELD   = 3'd2,
    OP_ADD     = 3'd3,
    OP_DISABLE = 3'd4,
    OP_ENABLE  = 3'd5,
    OP_SET_RUN = 3'd6,
    OP_RECALC  = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] slot;
    logic [7:0] prio;
    logic       runnable;
  } in_word_t;

  typedef struct packed {
    logic [3:0] current_task;
    logic       switched;
    logic       no_runnable;
    logic [9:0] slice_left;
  } out_word_t;

  typedef struct packed {
    op_e                  op;
    logic [SLOT_BITS-1:0] slot;
    logic [PRIO_BITS-1:0] prio;
    logic                 runnable;
  } cmd_t;

  // Best candidate seen so far, handed from one cell to the next.
  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] idx;
    logic [CNT_BITS-1:0]  cnt;
  } link_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]   cnt;
    logic [DEPTH_BITS-1:0] depth;
  } view_t;

  function automatic logic [CNT_BITS-1:0] fit_count(input logic [SUM_BITS-1:0] v);
    logic [CNT_BITS-1:0] r;
    if (v > SUM_BITS'(SLICE_MAX)) begin
      r = SLICE_MAX;
    end else begin
      r = v[CNT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/cpts_cell.sv
module cpts_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [cpts_pkg::SLOT_BITS-1:0] cell_id_i,
  input  cpts_pkg::cmd_t                 cmd_i,
  input  cpts_pkg::link_t                link_i,
  output cpts_pkg::link_t                link_o,
  output cpts_pkg::view_t                view_o
);

  logic                              valid_q, valid_d;
  logic                              run_q, run_d;
  logic [cpts_pkg::CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [cpts_pkg::PRIO_BITS-1:0]    prio_q, prio_d;
  logic [cpts_pkg::DEPTH_BITS-1:0]   depth_q, depth_d;
  cpts_pkg::link_t                   link_q, link_d;
  logic                              hit;
  logic                              is_first;
  logic [cpts_pkg::SUM_BITS-1:0]     recalc_sum;

  assign hit        = (cmd_i.slot == cell_id_i);
  assign is_first   = (cell_id_i == '0);
  assign recalc_sum = cpts_pkg::SUM_BITS'(cnt_q >> 1) + cpts_pkg::SUM_BITS'(prio_q);

  always_comb begin
    valid_d = valid_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    prio_d  = prio_q;
    depth_d = depth_q;
    case (cmd_i.op)
      cpts_pkg::OP_TICK: begin
        if (hit && cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      cpts_pkg::OP_YIELD: begin
        if (hit) begin
          cnt_d = '0;
        end
      end
      cpts_pkg::OP_ADD: begin
        if (hit) begin
          valid_d = 1'b1;
          run_d   = 1'b1;
          prio_d  = cmd_i.prio;
          cnt_d   = cpts_pkg::fit_count(cpts_pkg::SUM_BITS'(cmd_i.prio));
          depth_d = '0;
        end
      end
      cpts_pkg::OP_DISABLE: begin
        if (hit && depth_q != cpts_pkg::DEPTH_MAX) begin
          depth_d = depth_q + 1'b1;
        end
      end
      cpts_pkg::OP_ENABLE: begin
        if (hit && depth_q != '0) begin
          depth_d = depth_q - 1'b1;
        end
      end
      cpts_pkg::OP_SET_RUN: begin
        if (hit && valid_q) begin
          run_d = cmd_i.runnable;
        end
      end
      cpts_pkg::OP_RECALC: begin
        if (valid_q) begin
          cnt_d = cpts_pkg::fit_count(recalc_sum);
        end
      end
      default: begin
      end
    endcase
  end

  // A strictly greater count is needed to take over, so ties stay with the lower slot.
  always_comb begin
    link_d = link_i;
    if (valid_q && run_q && (!link_i.found || cnt_q > link_i.cnt)) begin
      link_d.found = 1'b1;
      link_d.idx   = cell_id_i;
      link_d.cnt   = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= is_first;
      run_q   <= is_first;
      cnt_q   <= '0;
      prio_q  <= cpts_pkg::PRIO_BITS'(is_first);
      depth_q <= '0;
      link_q  <= '0;
    end else begin
      valid_q <= valid_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      prio_q  <= prio_d;
      depth_q <= depth_d;
      link_q  <= link_d;
    end
  end

  assign link_o       = link_q;
  assign view_o.cnt   = cnt_q;
  assign view_o.depth = depth_q;

endmodule

### hdl/counter_priority_task_scheduler_unit.sv
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid_i / in_stall_o   | cpts_pkg::in_word_t
// out     | output    | out_valid_o / out_stall_i | cpts_pkg::out_word_t
//
// An event that needs no schedule goes straight from acceptance to ST_DONE and its result word.
// A schedule waits in ST_SCAN for the search to ripple through the chain of cells;
// a recompute adds a second pass through the chain. One event is worked on at a time.
// After reset slot 0 is the only task, valid and runnable with priority one and an empty slice.
// A stalled output word is held in its register while the next event is already taken in.

module counter_priority_task_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpts_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpts_pkg::out_word_t out_word_o
);

  // One-hot controller states: waiting for an event, waiting on the search chain,
  // and handing the result word to the output register.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                           state_q, state_d;
  logic [cpts_pkg::SCAN_BITS-1:0]   scan_q, scan_d;
  logic                             pass2_q, pass2_d;
  logic                             sched_q, sched_d;
  logic                             none_q, none_d;
  logic [cpts_pkg::SLOT_BITS-1:0]   before_q, before_d;
  logic [cpts_pkg::SLOT_BITS-1:0]   running_q, running_d;
  logic                             out_valid_q, out_valid_d;
  cpts_pkg::out_word_t              out_word_q, out_word_d;

  cpts_pkg::cmd_t                   cmd;
  cpts_pkg::link_t                  chain_in  [cpts_pkg::TASK_SLOTS];
  cpts_pkg::link_t                  chain_out [cpts_pkg::TASK_SLOTS];
  cpts_pkg::view_t                  views     [cpts_pkg::TASK_SLOTS];
  cpts_pkg::link_t                  best;
  cpts_pkg::view_t                  cur_view;
  logic                             accept;
  logic                             slot_ok;
  logic                             need_sched;
  logic                             scan_done;
  logic                             recalc;
  logic                             out_free;
  logic                             out_load;
  logic [cpts_pkg::PRIO_BITS-1:0]   prio_fit;

  // The row of cells. Each cell owns one task slot and passes the best candidate so far
  // on to its neighbour every cycle; the last cell's register holds the overall winner.
  for (genvar i = 0; i < cpts_pkg::TASK_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = '0;
    end else begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    cpts_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (cpts_pkg::SLOT_BITS'(i)),
      .cmd_i     (cmd),
      .link_i    (chain_in[i]),
      .link_o    (chain_out[i]),
      .view_o    (views[i])
    );
  end

  assign best       = chain_out[cpts_pkg::TASK_SLOTS-1];
  assign cur_view   = views[running_q];
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign slot_ok    = ({28'd0, in_word_i.slot} < 32'(cpts_pkg::TASK_SLOTS));
  assign scan_done  = (state_q == ST_SCAN) &&
                      (scan_q == cpts_pkg::SCAN_BITS'(cpts_pkg::TASK_SLOTS));
  // A recompute happens only on the first pass, when the best runnable count is zero.
  assign recalc     = scan_done && !pass2_q && best.found && (best.cnt == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;

  // A priority of zero is stored as one, so that a recompute never leaves a zero count.
  always_comb begin
    prio_fit = cpts_pkg::PRIO_BITS'(in_word_i.prio);
    if (prio_fit == '0) begin
      prio_fit = cpts_pkg::PRIO_BITS'(1);
    end
  end

  // Command broadcast to the cells. Events aimed at the running task carry its slot.
  always_comb begin
    cmd.op       = cpts_pkg::OP_NOP;
    cmd.slot     = running_q;
    cmd.prio     = prio_fit;
    cmd.runnable = in_word_i.runnable;
    need_sched   = 1'b0;
    if (accept) begin
      case (in_word_i.req_type)
        cpts_pkg::REQ_TICK: begin
          cmd.op     = cpts_pkg::OP_TICK;
          // The count reaches zero after the decrement when it is now zero or one.
          need_sched = (cur_view.cnt == '0 || cur_view.cnt == cpts_pkg::CNT_BITS'(1)) &&
                       (cur_view.depth == '0);
        end
        cpts_pkg::REQ_YIELD: begin
          cmd.op     = cpts_pkg::OP_YIELD;
          need_sched = 1'b1;
        end
        cpts_pkg::REQ_ADD: begin
          if (slot_ok) begin
            cmd.op   = cpts_pkg::OP_ADD;
            cmd.slot = cpts_pkg::SLOT_BITS'(in_word_i.slot);
          end
        end
        cpts_pkg::REQ_DISABLE: begin
          cmd.op = cpts_pkg::OP_DISABLE;
        end
        cpts_pkg::REQ_ENABLE: begin
          cmd.op = cpts_pkg::OP_ENABLE;
        end
        cpts_pkg::REQ_SET_RUN: begin
          if (slot_ok) begin
            cmd.op   = cpts_pkg::OP_SET_RUN;
            cmd.slot = cpts_pkg::SLOT_BITS'(in_word_i.slot);
          end
        end
        default: begin
        end
      endcase
    end else if (recalc) begin
      cmd.op = cpts_pkg::OP_RECALC;
    end
  end

  // Controller. The cells take the event at the accepting edge; a schedule then waits for
  // the chain to settle on the new state before it reads the winner.
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    pass2_d     = pass2_q;
    sched_d     = sched_q;
    none_d      = none_q;
    before_d    = before_q;
    running_d   = running_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          before_d = running_q;
          none_d   = 1'b0;
          sched_d  = need_sched;
          pass2_d  = 1'b0;
          scan_d   = '0;
          state_d  = need_sched ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          scan_d = scan_q + 1'b1;
        end else if (!best.found) begin
          // Nothing runnable: the running task is kept and no recompute takes place.
          none_d  = 1'b1;
          state_d = ST_DONE;
        end else if (recalc) begin
          pass2_d = 1'b1;
          scan_d  = '0;
        end else begin
          running_d = best.idx;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_word_d.current_task = 4'(running_q);
          out_word_d.switched     = (running_q != before_q);
          out_word_d.no_runnable  = none_q;
          out_word_d.slice_left   = cur_view.cnt;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      pass2_q     <= 1'b0;
      sched_q     <= 1'b0;
      none_q      <= 1'b0;
      before_q    <= '0;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pass2_q     <= pass2_d;
      sched_q     <= sched_d;
      none_q      <= none_d;
      before_q    <= before_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The running task only moves at the end of a search.
  a_running_moves_on_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |=> $stable(running_q))
    else $error("running task changed outside a schedule");

  // After a recompute every valid runnable task has a nonzero count, so one is found.
  a_second_pass_finds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_done && pass2_q) |-> best.found)
    else $error("second search pass found no runnable task");

  // Events without a schedule report neither a switch nor an empty run queue.
  a_quiet_without_schedule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !sched_q) |=> (!out_word_o.switched && !out_word_o.no_runnable))
    else $error("flags raised on an event that ran no schedule");

  // An empty run queue keeps the running task.
  a_none_keeps_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && none_q) |=> !out_word_o.switched)
    else $error("task switched although nothing was runnable");

endmodule
